// ----- hw/rtl/aes_ctr_stream_decryptor_top_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the aes ctr stream decryptor
// ----------------------------------------------------------------------------
`ifndef AES_CTR_STREAM_DECRYPTOR_TOP_MACROS_SVH
`define AES_CTR_STREAM_DECRYPTOR_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define ACSD_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// condition that always holds outside reset
`define ACSD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- hw/rtl/acsd_pkg.sv -----
// ----------------------------------------------------------------------------
// acsd_pkg
// shared types and functions of the aes-128 ctr stream decryptor
// ----------------------------------------------------------------------------
package acsd_pkg;

   localparam int BLOCK_BYTES   = 16;
   localparam int COUNTER_BYTES = 4;
   localparam int QUEUE_DEPTH   = 2;

   // register indexes
   localparam logic [2:0] REG_KEY_UPPER   = 3'd0;
   localparam logic [2:0] REG_KEY_LOWER   = 3'd1;
   localparam logic [2:0] REG_NONCE_UPPER = 3'd2;
   localparam logic [2:0] REG_NONCE_LOWER = 3'd3;
   localparam logic [2:0] REG_START_BLOCK = 3'd4;
   localparam logic [2:0] REG_TOTAL_SIZE  = 3'd5;

   // one gathered block handed from front to back
   typedef struct packed {
      logic [127:0] cipher;
      logic [127:0] counter;
      logic [4:0]   chunk;
      logic         done;
   } block_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit big-endian word
   function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
      return w[127 - 8*i -: 8];
   endfunction

   // one aes round on a state, byte 0 in the top bits
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int c = 0; c < 4; c++)
         for (int w = 0; w < 4; w++)
            t[4*c + w] = sbox(byte_at(s, 4*((c + w) & 3) + w));
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++)
         r[127 - 8*i -: 8] = t[i];
      return r ^ rk;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tmp;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      tmp = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ tmp;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

// ----- hw/rtl/acsd_front.sv -----
// ----------------------------------------------------------------------------
// acsd_front
// gathers request bytes into blocks, tracks counter and byte budget
// ----------------------------------------------------------------------------
module acsd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_cipher_byte,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   output logic                 blk_valid,
   input  logic                 blk_stall,
   output acsd_pkg::block_type  blk_data
);
   import acsd_pkg::*;

   logic [127:0] gather_ff, gather_in;
   logic [3:0]   count_ff, count_in;
   logic [127:0] counter_ff, counter_in;
   logic [31:0]  remaining_ff, remaining_in;
   logic [63:0]  nonce_upper_ff, nonce_lower_ff;
   logic [27:0]  start_ff;
   logic [63:0]  nu_eff, nl_eff;
   logic [27:0]  st_eff;
   logic [127:0] loaded;
   logic         accept;
   logic [4:0]   chunk;

   // queue of completed blocks
   block_type    q_mem [QUEUE_DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   fill_ff;
   logic         push;
   logic         pop;

   assign req_stall = (fill_ff == 2'(QUEUE_DEPTH)) && (count_ff == 4'(BLOCK_BYTES - 1));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (count_ff == 4'(BLOCK_BYTES - 1));
   assign pop       = blk_valid && !blk_stall;
   assign blk_valid = (fill_ff != 2'd0);
   assign blk_data  = q_mem[rd_ptr_ff];

   // counter reload from the freshly written value
   always_comb begin
      nu_eff = nonce_upper_ff;
      nl_eff = nonce_lower_ff;
      st_eff = start_ff;
      if (csr_write && csr_index == REG_NONCE_UPPER) nu_eff = csr_data;
      if (csr_write && csr_index == REG_NONCE_LOWER) nl_eff = csr_data;
      if (csr_write && csr_index == REG_START_BLOCK) st_eff = csr_data[27:0];
      loaded = {nu_eff, nl_eff};
      for (int i = 0; i < COUNTER_BYTES; i++)
         loaded[8*i +: 8] = (i < 4) ? 8'(32'(st_eff) >> (8*i)) : 8'h00;
   end

   assign chunk = (remaining_ff < 32'(BLOCK_BYTES)) ? remaining_ff[4:0] : 5'(BLOCK_BYTES);

   // gather, counter and budget
   always_comb begin
      gather_in    = gather_ff;
      count_in     = count_ff;
      counter_in   = counter_ff;
      remaining_in = remaining_ff;
      if (accept) begin
         gather_in[127 - 8*count_ff -: 8] = req_cipher_byte;
         count_in = count_ff + 4'd1;
         if (push) begin
            counter_in   = counter_ff + 128'd1;
            remaining_in = remaining_ff - 32'(chunk);
         end
      end
      if (csr_write && (csr_index == REG_NONCE_UPPER || csr_index == REG_NONCE_LOWER ||
                        csr_index == REG_START_BLOCK))
         counter_in = loaded;
      if (csr_write && csr_index == REG_TOTAL_SIZE)
         remaining_in = csr_data[31:0];
   end

   always_ff @(posedge clock) begin
      gather_ff <= gather_in;
      if (reset) begin
         count_ff       <= '0;
         counter_ff     <= '0;
         remaining_ff   <= '0;
         nonce_upper_ff <= '0;
         nonce_lower_ff <= '0;
         start_ff       <= '0;
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         fill_ff        <= '0;
      end else begin
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         remaining_ff <= remaining_in;
         if (csr_write && csr_index == REG_NONCE_UPPER) nonce_upper_ff <= csr_data;
         if (csr_write && csr_index == REG_NONCE_LOWER) nonce_lower_ff <= csr_data;
         if (csr_write && csr_index == REG_START_BLOCK) start_ff <= csr_data[27:0];
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff].cipher  <= {gather_ff[127:8], req_cipher_byte};
         q_mem[wr_ptr_ff].counter <= counter_ff;
         q_mem[wr_ptr_ff].chunk   <= chunk;
         q_mem[wr_ptr_ff].done    <= (chunk != 5'd0) && (remaining_ff == 32'(chunk));
      end
   end

   `include "aes_ctr_stream_decryptor_top_macros.svh"
   `ACSD_ASSERT_ALWAYS(a_fill_range, clock, reset, fill_ff <= 2'(QUEUE_DEPTH), "queue overflow")
   `ACSD_ASSERT_IMPL(a_no_pop_empty, clock, reset, fill_ff == 2'd0, !pop, "pop from empty queue")
   `ACSD_ASSERT_IMPL(a_push_room, clock, reset, push, fill_ff < 2'(QUEUE_DEPTH) || pop,
                     "push into full queue")
endmodule

// ----- hw/rtl/acsd_back.sv -----
// ----------------------------------------------------------------------------
// acsd_back
// iterative aes-128 keystream, one round per cycle, overlapped with byte output
// ----------------------------------------------------------------------------
module acsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [127:0]         key,
   input  logic                 blk_valid,
   output logic                 blk_stall,
   input  acsd_pkg::block_type  blk_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_plain_byte,
   output logic                 rsp_block_last,
   output logic                 rsp_stream_done
);
   import acsd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CIPH = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]   state_ff;
   logic [127:0] state_w_ff, rkey_ff, text_ff;
   logic [3:0]   round_ff;
   logic [7:0]   rcon_ff;
   logic [4:0]   chunk_ff;
   logic         done_ff;
   logic [127:0] emit_text_ff;
   logic [4:0]   emit_chunk_ff, idx_ff;
   logic         emit_done_ff;
   logic         emit_busy_ff;
   logic [127:0] next_key;
   logic         take;
   logic         fire;
   logic         handoff;

   assign next_key  = key_step(rkey_ff, rcon_ff);
   assign take      = blk_valid && (state_ff == ST_IDLE);
   assign blk_stall = (state_ff != ST_IDLE);
   assign fire      = rsp_valid && !rsp_stall;
   assign rsp_valid = emit_busy_ff;
   assign rsp_plain_byte  = byte_at(emit_text_ff, int'(idx_ff[3:0]));
   assign rsp_block_last  = (idx_ff + 5'd1 == emit_chunk_ff);
   assign rsp_stream_done = rsp_block_last && emit_done_ff;
   // finished block moves to the emitter once it is free or on its last byte
   assign handoff   = (state_ff == ST_DONE) && (!emit_busy_ff || (fire && rsp_block_last));

   // round sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  state_w_ff <= blk_data.counter ^ key;
                  rkey_ff    <= key;
                  rcon_ff    <= 8'h01;
                  round_ff   <= 4'd1;
                  text_ff    <= blk_data.cipher;
                  chunk_ff   <= blk_data.chunk;
                  done_ff    <= blk_data.done;
                  state_ff   <= ST_CIPH;
               end
            end
            ST_CIPH: begin
               state_w_ff <= aes_round(state_w_ff, next_key, round_ff == 4'd10);
               rkey_ff    <= next_key;
               rcon_ff    <= xtime(rcon_ff);
               round_ff   <= round_ff + 4'd1;
               if (round_ff == 4'd10) begin
                  text_ff  <= text_ff ^ aes_round(state_w_ff, next_key, 1'b1);
                  state_ff <= (chunk_ff == 5'd0) ? ST_IDLE : ST_DONE;
               end
            end
            ST_DONE: begin
               if (handoff) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // byte emitter
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
      end else if (handoff) begin
         emit_text_ff  <= text_ff;
         emit_chunk_ff <= chunk_ff;
         emit_done_ff  <= done_ff;
         idx_ff        <= '0;
         emit_busy_ff  <= 1'b1;
      end else if (fire) begin
         idx_ff <= idx_ff + 5'd1;
         if (rsp_block_last) emit_busy_ff <= 1'b0;
      end
   end

   `include "aes_ctr_stream_decryptor_top_macros.svh"
   `ACSD_ASSERT_IMPL(a_idx_in_chunk, clock, reset, rsp_valid, idx_ff < emit_chunk_ff,
                     "byte index past chunk")
   `ACSD_ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_CIPH,
                     round_ff >= 4'd1 && round_ff <= 4'd10, "round count out of range")
   `ACSD_ASSERT_IMPL(a_emit_hold, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid,
                     "response dropped under stall")
endmodule

// ----- hw/rtl/aes_ctr_stream_decryptor_top.sv -----
// ----------------------------------------------------------------------------
// aes_ctr_stream_decryptor_top
// aes-128 counter mode decryptor for a byte stream
// ----------------------------------------------------------------------------
// Takes one ciphertext byte per cycle unless req_stall is high. Every 16th
// byte closes a block that goes into a two-entry queue; the back end takes a
// block, runs one aes round per cycle and hands the result to a separate
// byte emitter, so the keystream of the next block is computed while the
// current one drains one plaintext byte per cycle when rsp_stall is low. A
// sustained stream runs at one request per cycle while the response side
// does not stall. The request side stalls only when two blocks wait in the
// queue and the next byte would close a third. No clearing pass after reset.
module aes_ctr_stream_decryptor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_cipher_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_plain_byte,
   output logic        rsp_block_last,
   output logic        rsp_stream_done,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import acsd_pkg::*;

   logic [63:0] key_upper_ff, key_lower_ff;
   logic        blk_valid, blk_stall;
   block_type   blk_data;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else begin
         if (csr_write && csr_index == REG_KEY_UPPER) key_upper_ff <= csr_data;
         if (csr_write && csr_index == REG_KEY_LOWER) key_lower_ff <= csr_data;
      end
   end

   acsd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cipher_byte,
      .csr_write, .csr_index, .csr_data,
      .blk_valid, .blk_stall, .blk_data
   );

   acsd_back u_back (
      .clock, .reset, .key({key_upper_ff, key_lower_ff}),
      .blk_valid, .blk_stall, .blk_data,
      .rsp_valid, .rsp_stall, .rsp_plain_byte, .rsp_block_last, .rsp_stream_done
   );
endmodule
